// ===== sv/cgo_pkg.sv =====
// shared constants, command codes and memory control struct for the cavity grid block
// no dependencies
`default_nettype none
package cgo_pkg;

  localparam int MAX_GRID_DEF   = 16;
  localparam int COORD_BITS_DEF = 20;
  localparam int POS_W          = 20;
  localparam int COMP_W         = 20;
  localparam int CNT_W          = 16;
  localparam int OPEN_W         = 13;
  localparam int RAD_W          = 20;
  localparam int CFG_W          = 60;
  localparam int CIDX_W         = 3;
  localparam int GS_W           = 5;

  localparam logic [GS_W-1:0]   GRID_RESET = 5'd16;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
  localparam logic [OPEN_W-1:0] OPEN_MAX   = '1;

  localparam logic [CIDX_W-1:0] REG_GRID    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_RADIUS  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BASIS_A = 3'd2;
  localparam logic [CIDX_W-1:0] REG_BASIS_B = 3'd3;
  localparam logic [CIDX_W-1:0] REG_BASIS_C = 3'd4;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ATOM  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cgo_cmd_e;

  typedef struct packed {
    logic rd_en;
    logic cnt_we;
    logic plc_we;
  } cgo_mem_ctl_t;

endpackage
`default_nettype wire

// ===== sv/cgo_div.sv =====
// restoring divider, one quotient bit per cycle
// uses no package items
`default_nettype none
module cgo_div #(
  parameter int NW = 27,
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, dvs_q, rem_d;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q, ge;
  logic [DW:0]   shifted, diff;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign rem_d   = ge ? diff[DW-1:0] : shifted[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

// ===== sv/cgo_store.sv =====
// point storage: occupancy counters and point places, registered read
// depends on cgo_pkg
`default_nettype none
module cgo_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int PLW   = 60
) (
  input  logic                      clk_i,
  input  cgo_pkg::cgo_mem_ctl_t     ctl_i,
  input  logic [AW-1:0]             rd_addr_i,
  input  logic [AW-1:0]             cnt_waddr_i,
  input  logic [cgo_pkg::CNT_W-1:0] cnt_wdata_i,
  input  logic [AW-1:0]             plc_waddr_i,
  input  logic [PLW-1:0]            plc_wdata_i,
  output logic [cgo_pkg::CNT_W-1:0] cnt_rdata_o,
  output logic [PLW-1:0]            plc_rdata_o
);
  import cgo_pkg::*;

  logic [CNT_W-1:0] cnt_mem [DEPTH];
  logic [PLW-1:0]   plc_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.cnt_we) begin
      cnt_mem[cnt_waddr_i] <= cnt_wdata_i;
    end
    if (ctl_i.rd_en) begin
      cnt_rdata_o <= cnt_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.plc_we) begin
      plc_mem[plc_waddr_i] <= plc_wdata_i;
    end
    if (ctl_i.rd_en) begin
      plc_rdata_o <= plc_mem[rd_addr_i];
    end
  end
endmodule
`default_nettype wire

// ===== sv/cavity_grid_occupancy.sv =====
// cavity grid occupancy: atom/query scan over g^3 points, one point per cycle
// from the store memory. clear sweeps all MAX_GRID^3 counters (one per cycle), then
// places each in-use point through three iterative dividers, one per axis. after
// reset the block runs a counter clearing pass over all MAX_GRID^3 counters with busy high.
// one item at a time; done_o is a one-cycle strobe that the receiver cannot stall.
`default_nettype none
module cavity_grid_occupancy #(
  parameter int MAX_GRID   = cgo_pkg::MAX_GRID_DEF,
  parameter int COORD_BITS = cgo_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        command_i,
  input  logic signed [cgo_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [cgo_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [cgo_pkg::POS_W-1:0]  pos_z_i,
  input  logic                              cfg_we_i,
  input  logic [cgo_pkg::CIDX_W-1:0]        cfg_idx_i,
  input  logic [cgo_pkg::CFG_W-1:0]         cfg_data_i,
  output logic                              done_o,
  output logic                              in_cavity_o,
  output logic [cgo_pkg::OPEN_W-1:0]        open_count_o
);
  import cgo_pkg::*;

  localparam int NPTS = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int AW   = $clog2(NPTS);
  localparam int GW   = $clog2(MAX_GRID + 1);
  localparam int FW   = GW + 2;
  localparam int PW   = COMP_W + FW;
  localparam int NUMW = PW + 2;
  localparam int DVW  = NUMW + 1;
  localparam int DENW = GW + 2;
  localparam int SVW  = (DVW + 1 > COORD_BITS + 1) ? DVW + 1 : COORD_BITS + 1;
  localparam int PLW  = 3 * COORD_BITS;
  localparam int DFW  = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 1;
  localparam int MGW  = POS_W + 1;
  localparam int SQW  = 2 * MGW - 1;
  localparam int SUMW = SQW + 2;
  localparam int R2W  = 2 * RAD_W;

  localparam logic [MGW-1:0] CLIP_D = MGW'(1) << POS_W;
  localparam logic signed [SVW-1:0] PHI = SVW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SVW-1:0] PLO = -PHI - SVW'(1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ZERO  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_SUM   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_DRAIN = 7'b1000000
  } state_e;

  state_e state_q;

  // configuration
  logic [GS_W-1:0]  grid_q;
  logic [RAD_W-1:0] radius_q;
  logic [CFG_W-1:0] basis_q [3];
  logic [R2W-1:0]   r2_q;

  // command context
  logic [1:0]              cmd_q;
  logic [GW-1:0]           g_q, g_eff;
  logic signed [POS_W-1:0] pos_q [3];
  logic                    clr_cmd_q;
  logic [AW-1:0]           zaddr_q;
  logic [GW-1:0]           i_q, j_q, k_q;
  logic [OPEN_W-1:0]       open_q, open_d, open_count_q;
  logic                    hit_q, hit_d, in_cav_q, done_q;
  logic                    pt_last, open_inc, item_end;
  logic [AW-1:0]           cur_addr;

  // placement datapath
  logic signed [FW-1:0]   fsel [3];
  logic signed [PW-1:0]   prod_q [3][3];
  logic signed [NUMW-1:0] num [3];
  logic [NUMW-1:0]        mag [3];
  logic [DVW-1:0]         div_in [3];
  logic [DVW-1:0]         quot [3];
  logic [2:0]             div_done;
  logic [2:0]             neg_q;
  logic [DENW-1:0]        den;
  logic signed [SVW-1:0]  sv [3];
  logic [PLW-1:0]         plc_wdata;
  logic                   div_start, div_all;

  // scan pipeline
  cgo_mem_ctl_t           mem_ctl;
  logic [CNT_W-1:0]       cnt_rdata, cnt_wdata;
  logic [PLW-1:0]         plc_rdata;
  logic [AW-1:0]          cnt_waddr;
  logic                   s1_v_q, s2_v_q, s3_v_q;
  logic [AW-1:0]          s1_addr_q, s2_addr_q, s3_addr_q;
  logic [CNT_W-1:0]       s2_cnt_q, s3_cnt_q;
  logic [MGW-1:0]         s1_mag [3];
  logic [MGW-1:0]         s2_mag_q [3];
  logic [SQW-1:0]         s3_sq_q [3];
  logic [SUMW-1:0]        dsum;
  logic                   in_rad, is_atom, is_query, bump;

  function automatic logic signed [FW-1:0] fact(input logic [GW-1:0] n,
                                                input logic [GW-1:0] g);
    return $signed({1'b0, n, 1'b1}) - $signed({2'b00, g});
  endfunction

  // effective grid size
  always_comb begin
    if (grid_q == '0) begin
      g_eff = GW'(1);
    end else if (8'(grid_q) > 8'(MAX_GRID)) begin
      g_eff = GW'(MAX_GRID);
    end else begin
      g_eff = GW'(grid_q);
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign is_atom  = (cmd_q == CMD_ATOM);
  assign is_query = (cmd_q == CMD_QUERY);
  assign pt_last  = (i_q == g_q - GW'(1)) && (j_q == g_q - GW'(1)) && (k_q == g_q - GW'(1));
  assign cur_addr = AW'(i_q) * AW'(MAX_GRID * MAX_GRID) + AW'(j_q) * AW'(MAX_GRID) + AW'(k_q);

  // placement: numerator per axis, rounded division, saturation
  assign fsel[0] = fact(i_q, g_q);
  assign fsel[1] = fact(j_q, g_q);
  assign fsel[2] = fact(k_q, g_q);
  assign den     = DENW'((DENW'(g_q) + DENW'(1)) << 1);
  assign div_start = (state_q == ST_SUM);
  assign div_all   = &div_done;

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    assign num[ax] = NUMW'(prod_q[ax][0]) + NUMW'(prod_q[ax][1]) + NUMW'(prod_q[ax][2]);
    assign mag[ax] = num[ax][NUMW-1] ? NUMW'(-num[ax]) : NUMW'(num[ax]);
    // half the divisor is g+1, added before the divide for round to nearest
    assign div_in[ax] = DVW'(mag[ax]) + DVW'(g_q) + DVW'(1);

    cgo_div #(.NW(DVW), .DW(DENW)) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (div_start),
      .dividend_i(div_in[ax]),
      .divisor_i (den),
      .done_o    (div_done[ax]),
      .quot_o    (quot[ax])
    );

    always_comb begin
      logic signed [SVW-1:0] qs;
      qs = $signed(SVW'(quot[ax]));
      sv[ax] = neg_q[ax] ? -qs : qs;
      if (sv[ax] > PHI) begin
        sv[ax] = PHI;
      end else if (sv[ax] < PLO) begin
        sv[ax] = PLO;
      end
    end
    assign plc_wdata[ax*COORD_BITS +: COORD_BITS] = sv[ax][COORD_BITS-1:0];

    always_ff @(posedge clk_i) begin
      if (state_q == ST_MUL) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[ax][r] <= $signed(basis_q[r][ax*COMP_W +: COMP_W]) * fsel[r];
        end
      end
      if (state_q == ST_SUM) begin
        neg_q[ax] <= num[ax][NUMW-1];
      end
    end

    // scan stage 1: clipped distance per axis
    always_comb begin
      logic signed [DFW-1:0] d;
      logic [DFW-1:0]        a;
      d = DFW'(pos_q[ax]) - DFW'($signed(plc_rdata[ax*COORD_BITS +: COORD_BITS]));
      a = d[DFW-1] ? DFW'(-d) : DFW'(d);
      s1_mag[ax] = (a > DFW'(CLIP_D)) ? CLIP_D : MGW'(a);
    end
  end

  // scan pipeline
  assign dsum   = SUMW'(s3_sq_q[0]) + SUMW'(s3_sq_q[1]) + SUMW'(s3_sq_q[2]);
  assign in_rad = dsum < SUMW'(r2_q);
  assign bump   = s3_v_q && is_atom && in_rad && (s3_cnt_q != CNT_MAX);

  always_ff @(posedge clk_i) begin
    r2_q      <= R2W'(radius_q) * R2W'(radius_q);
    s1_addr_q <= cur_addr;
    s2_addr_q <= s1_addr_q;
    s3_addr_q <= s2_addr_q;
    s2_cnt_q  <= cnt_rdata;
    s3_cnt_q  <= s2_cnt_q;
    for (int a = 0; a < 3; a++) begin
      s2_mag_q[a] <= s1_mag[a];
      s3_sq_q[a]  <= SQW'(s2_mag_q[a]) * SQW'(s2_mag_q[a]);
    end
  end

  always_comb begin
    mem_ctl.rd_en  = (state_q == ST_SCAN);
    mem_ctl.plc_we = (state_q == ST_DIV) && div_all;
    mem_ctl.cnt_we = (state_q == ST_ZERO) || bump;
    if (state_q == ST_ZERO) begin
      cnt_waddr = zaddr_q;
      cnt_wdata = '0;
    end else begin
      cnt_waddr = s3_addr_q;
      cnt_wdata = s3_cnt_q + CNT_W'(1);
    end
  end

  cgo_store #(.DEPTH(NPTS), .AW(AW), .PLW(PLW)) u_store (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (cur_addr),
    .cnt_waddr_i(cnt_waddr),
    .cnt_wdata_i(cnt_wdata),
    .plc_waddr_i(cur_addr),
    .plc_wdata_i(plc_wdata),
    .cnt_rdata_o(cnt_rdata),
    .plc_rdata_o(plc_rdata)
  );

  // open count and hit, counter stays zero after an atom unless it was in range
  // both are held at zero while idle so a new request starts from zero
  assign open_inc = ((state_q == ST_DIV) && div_all) ||
                    (s3_v_q && (s3_cnt_q == '0) && !(is_atom && in_rad));
  assign open_d   = (state_q == ST_IDLE) ? '0 :
                    ((open_inc && open_q != OPEN_MAX) ? open_q + OPEN_W'(1) : open_q);
  assign hit_d    = (state_q == ST_IDLE) ? 1'b0 :
                    (hit_q | (s3_v_q && is_query && (s3_cnt_q == '0) && in_rad));
  assign item_end = ((state_q == ST_DIV) && div_all && pt_last) ||
                    ((state_q == ST_DRAIN) && !(s1_v_q || s2_v_q || s3_v_q));

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) begin
      cmd_q    <= command_i;
      g_q      <= g_eff;
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_ZERO;
      zaddr_q      <= '0;
      clr_cmd_q    <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      open_q       <= '0;
      hit_q        <= 1'b0;
      open_count_q <= '0;
      in_cav_q     <= 1'b0;
      done_q       <= 1'b0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      grid_q       <= GRID_RESET;
      radius_q     <= '0;
      basis_q[0]   <= '0;
      basis_q[1]   <= '0;
      basis_q[2]   <= '0;
    end else begin
      done_q <= item_end;
      s1_v_q <= mem_ctl.rd_en;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      open_q <= open_d;
      hit_q  <= hit_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID:    grid_q     <= cfg_data_i[GS_W-1:0];
          REG_RADIUS:  radius_q   <= cfg_data_i[RAD_W-1:0];
          REG_BASIS_A: basis_q[0] <= cfg_data_i;
          REG_BASIS_B: basis_q[1] <= cfg_data_i;
          REG_BASIS_C: basis_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      // point walk shared by placement and scan
      if (((state_q == ST_DIV) && div_all) || (state_q == ST_SCAN)) begin
        if (k_q == g_q - GW'(1)) begin
          k_q <= '0;
          if (j_q == g_q - GW'(1)) begin
            j_q <= '0;
            i_q <= i_q + GW'(1);
          end else begin
            j_q <= j_q + GW'(1);
          end
        end else begin
          k_q <= k_q + GW'(1);
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (start) begin
            i_q    <= '0;
            j_q    <= '0;
            k_q    <= '0;
            case (command_i)
              CMD_CLEAR: begin
                clr_cmd_q <= 1'b1;
                zaddr_q   <= '0;
                state_q   <= ST_ZERO;
              end
              default: state_q <= ST_SCAN;
            endcase
          end
        end
        ST_ZERO: begin
          zaddr_q <= zaddr_q + AW'(1);
          if (zaddr_q == AW'(NPTS - 1)) begin
            state_q <= clr_cmd_q ? ST_MUL : ST_IDLE;
          end
        end
        ST_MUL: state_q <= ST_SUM;
        ST_SUM: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_all) begin
            if (pt_last) begin
              state_q      <= ST_IDLE;
              open_count_q <= open_d;
              in_cav_q     <= 1'b0;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_SCAN: begin
          if (pt_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!(s1_v_q || s2_v_q || s3_v_q)) begin
            state_q      <= ST_IDLE;
            open_count_q <= open_d;
            in_cav_q     <= hit_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o       = done_q;
  assign in_cavity_o  = in_cav_q;
  assign open_count_o = open_count_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");
  a_cav_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && in_cavity_o) |-> (cmd_q == CMD_QUERY)) else $error("cavity hit on non-query");
  a_wr_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.cnt_we && mem_ctl.plc_we)) else $error("count and place written together");
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted but block not busy");

endmodule
`default_nettype wire
